// ===== rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic [31:0]        tag;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_tag;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e           op;
    logic               found;
    logic signed [31:0] key;
    logic [31:0]        tag;
  } cell_ctrl_t;

endpackage

// ===== rtl/skt_cell.sv =====
module skt_cell (
  input  logic                       clk_i,
  input  skt_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       occ_i,
  input  logic                       wrap_i,
  input  logic                       prev_less_i,
  input  logic signed [31:0]         prev_key_i,
  input  logic [31:0]                prev_tag_i,
  input  logic signed [31:0]         next_key_i,
  input  logic [31:0]                next_tag_i,
  input  logic signed [31:0]         head_key_i,
  input  logic [31:0]                head_tag_i,
  output logic                       less_o,
  output logic                       match_o,
  output logic signed [31:0]         key_o,
  output logic [31:0]                tag_o
);
  import skt_pkg::*;

  logic signed [31:0] key_q, key_d;
  logic [31:0]        tag_q, tag_d;

  assign less_o  = occ_i && (key_q < ctrl_i.key);
  assign match_o = occ_i && (key_q == ctrl_i.key);
  assign key_o   = key_q;
  assign tag_o   = tag_q;

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        // first cell not below the new key takes it, later cells move down
        if (!less_o) begin
          if (prev_less_i) begin
            key_d = ctrl_i.key;
            tag_d = ctrl_i.tag;
          end else begin
            key_d = prev_key_i;
            tag_d = prev_tag_i;
          end
        end
      end
      OP_DELETE: begin
        if (ctrl_i.found && !less_o) begin
          key_d = next_key_i;
          tag_d = next_tag_i;
        end
      end
      OP_ROTATE: begin
        if (wrap_i) begin
          key_d = head_key_i;
          tag_d = head_tag_i;
        end else begin
          key_d = next_key_i;
          tag_d = next_tag_i;
        end
      end
      default: begin
        key_d = key_q;
        tag_d = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: up to CAPACITY records held in ascending signed key order
// in a chain of cells, each cell holding one key and tag.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command per
// transfer: insert a record, delete the first record with a matching key,
// or list all records. Output channel (out_valid_o/out_ready_i, out_data_o)
// returns results; last marks the final result of a command.
// Insert and delete: the command is registered, then in the execute state every
// cell compares against the key and the chain shifts by one place, while the
// result is written to the output register; this waits while the output is
// stalled, and a new command is taken only after the result is registered.
// List: the chain rotates by one cell per cycle while the output drains,
// cell 0 feeding the output, giving one record per cycle; the chain ends
// in its original order. An empty table gives one empty status.
// A stalled receiver holds the output register; the chain then holds too and
// no further command is taken until the current one has finished.
// Reset empties the table (count cleared) and drops any pending result
// (output valid cleared, output data left as it is);
// cell contents are not cleared and are never read beyond the count.
module sorted_key_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  skt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output skt_pkg::out_t  out_data_o
);
  import skt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  in_t              req_q;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  cell_ctrl_t         ctrl;
  logic               out_free;
  logic               full, empty, found, list_last;
  logic [CNT_W-1:0]   count_m1;

  logic               less  [CAPACITY];
  logic               match [CAPACITY];
  logic               occ   [CAPACITY];
  logic               wrap  [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic signed [31:0] cell_key [CAPACITY];
  logic [31:0]        cell_tag [CAPACITY];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - 1'b1;
  assign found     = |match_vec;
  assign list_last = ({1'b0, idx_q} == count_m1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]       = (CNT_W'(i) < count_q);
    assign wrap[i]      = (CNT_W'(i) == count_m1);
    assign match_vec[i] = match[i];

    skt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .wrap_i      (wrap[i]),
      .prev_less_i ((i == 0) ? 1'b1 : less[(i == 0) ? 0 : i - 1]),
      .prev_key_i  (cell_key[(i == 0) ? 0 : i - 1]),
      .prev_tag_i  (cell_tag[(i == 0) ? 0 : i - 1]),
      .next_key_i  (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
      .next_tag_i  (cell_tag[(i == CAPACITY - 1) ? i : i + 1]),
      .head_key_i  (cell_key[0]),
      .head_tag_i  (cell_tag[0]),
      .less_o      (less[i]),
      .match_o     (match[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl.op     = OP_HOLD;
    ctrl.found  = found;
    ctrl.key    = req_q.key;
    ctrl.tag    = req_q.tag;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_d.status  = ST_OK;
          out_d.out_key = '0;
          out_d.out_tag = '0;
          out_d.last    = 1'b1;
          state_d       = S_IDLE;
          case (req_q.cmd)
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_d.status = ST_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            CMD_DELETE: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_d.status = ST_EMPTY;
              end else if (!found) begin
                out_d.status = ST_NOT_FOUND;
              end else begin
                ctrl.op = OP_DELETE;
                count_d = count_q - 1'b1;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_LIST;
              end
            end
            default: begin
              // unused code: drop it, no result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = ST_OK;
          out_d.out_key = cell_key[0];
          out_d.out_tag = cell_tag[0];
          out_d.last    = list_last;
          ctrl.op       = OP_ROTATE;
          idx_d         = idx_q + 1'b1;
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (count_q != '0))
    else $error("listing an empty table");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_INSERT) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the table");

  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_DELETE) |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the table");

  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && out_free && list_last) |=>
      (state_q == S_IDLE && out_valid_q && out_q.last))
    else $error("list did not finish on its last record");
`endif

endmodule
